@@ hdl/multichannel_interval_timer_defines.svh @@
// Assertion macros shared by the interval timer RTL.
// Used by files that include this header; no other dependencies.
`ifndef MULTICHANNEL_INTERVAL_TIMER_DEFINES_SVH
`define MULTICHANNEL_INTERVAL_TIMER_DEFINES_SVH

// Checked on every rising clock edge, ignored while reset is asserted.
`define MIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, including during reset.
`define MIT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hdl/mit_pkg.sv @@
// Package for the multichannel interval timer: widths, codes and types.
// No dependencies; used by the interfaces and all timer modules.
package mit_pkg;

  localparam int unsigned CHANNELS     = 4;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned OP_W         = 3;
  localparam int unsigned CHAN_FIELD_W = 2;
  localparam int unsigned IRQ_W        = 4;

  localparam logic [DATA_W-1:0] DIVIDER_RESET = 32'd50000;
  localparam logic [DATA_W-1:0] VISIBLE_RESET = 32'hFFFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_CMP   = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    RUN_STOPPED = 3'b001,
    RUN_READY   = 3'b010,
    RUN_RUNNING = 3'b100
  } run_e;

  // Per-channel controls for one processed item.
  typedef struct packed {
    logic              evt;
    logic              start;
    logic              stop;
    logic              cmp_wr;
    logic [DATA_W-1:0] data;
  } chan_ctrl_t;

endpackage

@@ hdl/mit_if.sv @@
// Handshake interfaces of the interval timer: item input, result output,
// and divider configuration. Depends on mit_pkg.
interface mit_in_if import mit_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [CHAN_FIELD_W-1:0] channel;
  logic [DATA_W-1:0]       write_data;

  modport source (output valid, op, channel, write_data, input ready);
  modport sink   (input valid, op, channel, write_data, output ready);
endinterface

interface mit_out_if import mit_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [IRQ_W-1:0]  irq_mask;

  modport source (output valid, read_data, irq_mask, input ready);
  modport sink   (input valid, read_data, irq_mask, output ready);
endinterface

interface mit_cfg_if import mit_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] prescale_divider;

  modport source (output valid, prescale_divider, input ready);
  modport sink   (input valid, prescale_divider, output ready);
endinterface

@@ hdl/mit_channel.sv @@
// One timer channel: run state, event count, compare value and down-count.
// Depends on mit_pkg.
module mit_channel import mit_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  chan_ctrl_t        ctrl_i,
  output logic              irq_o,
  output logic [DATA_W-1:0] visible_o
);

  run_e              run_q, run_d;
  logic [DATA_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0] cmp_q, cmp_d;
  logic [DATA_W-1:0] vis_q, vis_d;
  logic [DATA_W-1:0] cnt_next;
  logic              active;

  always_comb begin
    run_d    = run_q;
    cnt_d    = cnt_q;
    cmp_d    = cmp_q;
    vis_d    = vis_q;
    irq_o    = 1'b0;
    active   = (run_q == RUN_READY) || (run_q == RUN_RUNNING);
    // A ready channel restarts at zero; a running one advances.
    cnt_next = (run_q == RUN_READY) ? '0 : cnt_q + DATA_W'(1);

    priority if (ctrl_i.evt && active) begin
      cnt_d = cnt_next;
      vis_d = cmp_q - cnt_next;
      if (cnt_next >= cmp_q) begin
        run_d = RUN_READY;
        irq_o = 1'b1;
      end else begin
        run_d = RUN_RUNNING;
      end
    end else if (ctrl_i.start) begin
      run_d = RUN_READY;
    end else if (ctrl_i.stop) begin
      run_d = RUN_STOPPED;
    end else if (ctrl_i.cmp_wr) begin
      cmp_d = ctrl_i.data;
      if (run_q == RUN_RUNNING) begin
        run_d = RUN_READY;
      end
    end else begin
      // Nothing addressed to this channel: every register holds.
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= RUN_STOPPED;
      cnt_q <= '0;
      cmp_q <= '0;
      vis_q <= VISIBLE_RESET;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
      cmp_q <= cmp_d;
      vis_q <= vis_d;
    end
  end

  assign visible_o = vis_q;

endmodule

@@ hdl/multichannel_interval_timer.sv @@
// Multichannel interval timer with a shared prescaler.
// Channels: in_if takes one item (op, channel, write_data) per transfer;
// out_if returns exactly one result (read_data, irq_mask) per item, in order.
// cfg_if writes the prescale divider; it is always ready and should be
// used only while no item is in flight.
// Path: an accepted item is held in the input register and is processed
// when it advances, which loads the result register; a stalled out_if
// can keep it waiting in the input register. Throughput is one item per
// cycle while out_if is ready: the input register feeds one pass of
// per-channel logic (an increment, a subtract and a compare per channel)
// straight into the result register.
// Reset: all channels stopped, counts and compares zero, down-counts all
// ones, prescaler phase zero, divider 50000, both registers empty.
// Stall: when out_if is not ready the result register holds; the input
// register still takes one more item, and in_if.ready drops only when both
// registers are full. Nothing is lost or repeated.
// Depends on mit_pkg, the mit_*_if interfaces and mit_channel.
`include "multichannel_interval_timer_defines.svh"

module multichannel_interval_timer import mit_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mit_in_if.sink     in_if,
  mit_out_if.source  out_if,
  mit_cfg_if.sink    cfg_if
);

  logic                    in_valid_q;
  logic [OP_W-1:0]         op_q;
  logic [CHAN_FIELD_W-1:0] chan_q;
  logic [DATA_W-1:0]       data_q;
  logic                    out_valid_q;
  logic [DATA_W-1:0]       read_data_q;
  logic [IRQ_W-1:0]        irq_q;
  logic [DATA_W-1:0]       div_q;
  logic [DATA_W-1:0]       phase_q, phase_d;

  logic              advance;
  logic              in_take;
  op_e               op;
  logic              tick;
  logic              evt;
  logic [DATA_W-1:0] div_eff;
  logic [DATA_W-1:0] phase_inc;
  logic [DATA_W-1:0] chan_ext;
  logic [DATA_W-1:0] rd_val;
  logic [IRQ_W-1:0]  irq_val;

  chan_ctrl_t        ctrl [CHANNELS];
  logic              chan_irq [CHANNELS];
  logic [DATA_W-1:0] vis [CHANNELS];

  assign op       = op_e'(op_q);
  assign advance  = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_take  = in_if.valid && in_if.ready;
  assign in_if.ready  = !in_valid_q || advance;
  assign cfg_if.ready = 1'b1;
  assign chan_ext = {{(DATA_W - CHAN_FIELD_W){1'b0}}, chan_q};

  // Prescaler: an event on phase zero, a divider of zero acts as one.
  assign tick      = advance && (op == OP_TICK);
  assign evt       = tick && (phase_q == '0);
  assign div_eff   = (div_q == '0) ? DATA_W'(1) : div_q;
  assign phase_inc = phase_q + DATA_W'(1);

  always_comb begin
    phase_d = phase_q;
    if (tick) begin
      phase_d = (phase_inc >= div_eff) ? '0 : phase_inc;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    assign ctrl[c].evt    = evt;
    assign ctrl[c].start  = advance && (op == OP_START) && data_q[c];
    assign ctrl[c].stop   = advance && (op == OP_STOP) && data_q[c];
    assign ctrl[c].cmp_wr = advance && (op == OP_CMP) && (chan_ext == DATA_W'(c));
    assign ctrl[c].data   = data_q;

    mit_channel u_channel (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl[c]),
      .irq_o     (chan_irq[c]),
      .visible_o (vis[c])
    );
  end

  // Only the first IRQ_W channels have an interrupt bit.
  for (genvar i = 0; i < IRQ_W; i++) begin : g_irq
    if (i < CHANNELS) begin : g_present
      assign irq_val[i] = chan_irq[i];
    end else begin : g_absent
      assign irq_val[i] = 1'b0;
    end
  end

  always_comb begin
    rd_val = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (chan_ext == DATA_W'(c)) begin
        rd_val = vis[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      div_q       <= DIVIDER_RESET;
      phase_q     <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_if.valid) begin
        div_q <= cfg_if.prescale_divider;
      end
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q   <= in_if.op;
      chan_q <= in_if.channel;
      data_q <= in_if.write_data;
    end
    if (advance) begin
      read_data_q <= (op == OP_READ) ? rd_val : '0;
      irq_q       <= (op == OP_TICK) ? irq_val : '0;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.read_data = read_data_q;
  assign out_if.irq_mask  = irq_q;

  `MIT_ASSERT(a_irq_only_on_tick, advance && (op != OP_TICK) |=> irq_q == '0, "stray irq")
  `MIT_ASSERT(a_read_only_on_read, advance && (op != OP_READ) |=> read_data_q == '0, "stray data")
  `MIT_ASSERT(a_held_item_kept, in_valid_q && !advance |=> in_valid_q && $stable(op_q), "item lost")
  `MIT_ASSERT_ALWAYS(a_no_take_when_full, in_valid_q && !advance |-> !in_if.ready, "taken full")

endmodule

@@ tb/sv/multichannel_interval_timer_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the multichannel interval timer: watches the item, result and
// divider channels, predicts every result and compares it in order.
// Depends on mit_pkg and the mit_*_if interfaces.
module multichannel_interval_timer_checker import mit_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mit_in_if           in_if,
  mit_out_if          out_if,
  mit_cfg_if          cfg_if,
  output int unsigned mismatch_count_o,
  output int unsigned outstanding_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [IRQ_W-1:0]  irq_mask;
  } timer_result_t;

  logic [DATA_W-1:0] divider;
  logic [DATA_W-1:0] phase;
  run_e              run_state     [CHANNELS];
  logic [DATA_W-1:0] event_count   [CHANNELS];
  logic [DATA_W-1:0] compare_value [CHANNELS];
  logic [DATA_W-1:0] down_count    [CHANNELS];
  timer_result_t     expected_q    [$];
  int unsigned       mismatches;
  int unsigned       results_seen;

  function automatic void clear_timer();
    divider = DIVIDER_RESET;
    phase   = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      run_state[c]     = RUN_STOPPED;
      event_count[c]   = '0;
      compare_value[c] = '0;
      down_count[c]    = VISIBLE_RESET;
    end
  endfunction

  // One prescaler event: ready channels restart at zero, running ones advance.
  function automatic logic [IRQ_W-1:0] count_event();
    logic [IRQ_W-1:0] irq;
    logic             counted;
    irq = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      counted = 1'b1;
      case (run_state[c])
        RUN_READY: begin
          run_state[c]   = RUN_RUNNING;
          event_count[c] = '0;
        end
        RUN_RUNNING: event_count[c] = event_count[c] + 1'b1;
        default: counted = 1'b0;
      endcase
      if (counted) begin
        down_count[c] = compare_value[c] - event_count[c];
        if (event_count[c] >= compare_value[c]) begin
          run_state[c] = RUN_READY;
          if (c < IRQ_W) irq[c] = 1'b1;
        end
      end
    end
    return irq;
  endfunction

  function automatic timer_result_t predict_result(logic [OP_W-1:0]         op,
                                                   logic [CHAN_FIELD_W-1:0] ch,
                                                   logic [DATA_W-1:0]       data);
    timer_result_t     res;
    logic [DATA_W-1:0] div;
    res = '0;
    case (op)
      OP_TICK: begin
        // A divider of zero counts as one.
        div = (divider == '0) ? 32'd1 : divider;
        if (phase == '0) res.irq_mask = count_event();
        phase = phase + 1'b1;
        if (phase >= div) phase = '0;
      end
      OP_START: begin
        for (int c = 0; c < CHANNELS; c++) if (data[c]) run_state[c] = RUN_READY;
      end
      OP_STOP: begin
        for (int c = 0; c < CHANNELS; c++) if (data[c]) run_state[c] = RUN_STOPPED;
      end
      OP_CMP: begin
        if (ch < CHANNELS) begin
          compare_value[ch] = data;
          if (run_state[ch] == RUN_RUNNING) run_state[ch] = RUN_READY;
        end
      end
      OP_READ: begin
        if (ch < CHANNELS) res.read_data = down_count[ch];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void note_failure(string what);
    if (mismatches < REPORT_LIMIT) $display("%0t result %0d: %s", $realtime, results_seen, what);
    mismatches++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t want;
    if (!rst_ni) begin
      clear_timer();
      expected_q.delete();
      mismatches       = 0;
      results_seen     = 0;
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) divider = cfg_if.prescale_divider;
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          note_failure($sformatf("unexpected transfer, read_data %h irq_mask %h",
                                 out_if.read_data, out_if.irq_mask));
        end else begin
          want = expected_q.pop_front();
          if (out_if.read_data !== want.read_data || out_if.irq_mask !== want.irq_mask)
            note_failure($sformatf("expected read_data %h irq_mask %h, got %h %h",
                                   want.read_data, want.irq_mask,
                                   out_if.read_data, out_if.irq_mask));
        end
        results_seen++;
      end
      if (in_if.valid && in_if.ready)
        expected_q.push_back(predict_result(in_if.op, in_if.channel, in_if.write_data));
      mismatch_count_o <= mismatches;
      outstanding_o    <= expected_q.size();
    end
  end

endmodule

@@ tb/sv/multichannel_interval_timer_tb.sv @@
`timescale 1ns / 100ps
// Top of the interval timer testbench: clock, reset, divider writes and item stimulus.
// Depends on mit_pkg, the mit_*_if interfaces, the timer and its checker.
module multichannel_interval_timer_tb;
  import mit_pkg::*;

  localparam int unsigned     CYCLE_LIMIT = 400000;
  localparam int unsigned     DRAIN_LIMIT = 2000;
  localparam logic [OP_W-1:0] OP_RSVD_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_HI  = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count;

  mit_in_if  in_if ();
  mit_out_if out_if ();
  mit_cfg_if cfg_if ();

  multichannel_interval_timer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  multichannel_interval_timer_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_if            (in_if),
    .out_if           (out_if),
    .cfg_if           (cfg_if),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    out_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic issue_access(logic [OP_W-1:0] op, logic [CHAN_FIELD_W-1:0] ch,
                              logic [DATA_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.op         <= op;
    in_if.channel    <= ch;
    in_if.write_data <= data;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // The extra edge lets the checker count the last transfer before we look.
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_divider(logic [DATA_W-1:0] div);
    wait_for_results();
    repeat (4) @(posedge clk_i);
    cfg_if.valid            <= 1'b1;
    cfg_if.prescale_divider <= div;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly ticks with small compare values, so channels match and restart often.
  task automatic issue_random_access();
    int unsigned             pick;
    logic [OP_W-1:0]         op;
    logic [CHAN_FIELD_W-1:0] ch;
    logic [DATA_W-1:0]       data;
    pick = $urandom_range(99);
    ch   = CHAN_FIELD_W'($urandom_range((1 << CHAN_FIELD_W) - 1));
    data = $urandom;
    if (pick < 55) begin
      op = OP_TICK;
    end else if (pick < 65) begin
      op   = OP_START;
      data = $urandom_range((1 << CHANNELS) - 1);
      if ($urandom_range(3) == 0) data[DATA_W-1:CHANNELS] = (DATA_W - CHANNELS)'($urandom);
    end else if (pick < 70) begin
      op   = OP_STOP;
      data = 32'd1 << $urandom_range(CHANNELS - 1);
      if ($urandom_range(3) == 0) data[DATA_W-1:CHANNELS] = (DATA_W - CHANNELS)'($urandom);
    end else if (pick < 82) begin
      op   = OP_CMP;
      pick = $urandom_range(99);
      if (pick < 70) data = $urandom_range(6);
      else if (pick < 85) data = $urandom_range(40, 7);
      else if (pick < 95) data = $urandom;
      else data = VISIBLE_RESET;
    end else if (pick < 97) begin
      op = OP_READ;
    end else begin
      op = OP_W'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
    end
    issue_access(op, ch, data);
  endtask

  task automatic run_phase(logic [DATA_W-1:0] div, int unsigned idle_pct,
                           int unsigned stall_pct, int unsigned count, bit pause_mid);
    write_divider(div);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int unsigned i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2) wait_for_results();
      issue_random_access();
    end
  endtask

  initial begin
    int unsigned drain_cycles;
    send_idle_pct           = 0;
    recv_stall_pct          = 0;
    rst_ni                  <= 1'b0;
    in_if.valid             <= 1'b0;
    in_if.op                <= OP_TICK;
    in_if.channel           <= '0;
    in_if.write_data        <= '0;
    cfg_if.valid            <= 1'b0;
    cfg_if.prescale_divider <= DIVIDER_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset divider: only the first tick is an event.
    issue_access(OP_READ, 2'd0, '0);
    issue_access(OP_CMP, 2'd0, '0);
    issue_access(OP_CMP, 2'd1, VISIBLE_RESET);
    issue_access(OP_CMP, 2'd2, 32'd2);
    issue_access(OP_CMP, 2'd3, 32'd1);
    issue_access(OP_START, 2'd0, VISIBLE_RESET);
    issue_access(OP_TICK, 2'd0, '0);
    issue_access(OP_READ, 2'd2, '0);
    issue_access(OP_TICK, 2'd3, VISIBLE_RESET);
    issue_access(OP_RSVD_LO, 2'd3, VISIBLE_RESET);
    issue_access(OP_W'(OP_RSVD_LO + 1'b1), 2'd1, 32'h5A5A_A5A5);
    issue_access(OP_RSVD_HI, 2'd2, '0);

    // A divider of zero gives an event on every tick.
    write_divider('0);
    issue_access(OP_TICK, 2'd0, '0);
    issue_access(OP_START, 2'd0, 32'h2);
    issue_access(OP_TICK, 2'd0, '0);
    issue_access(OP_CMP, 2'd2, 32'd3);
    issue_access(OP_TICK, 2'd0, '0);
    issue_access(OP_READ, 2'd1, '0);
    issue_access(OP_READ, 2'd2, '0);
    issue_access(OP_READ, 2'd3, '0);
    issue_access(OP_STOP, 2'd0, 32'hFFFF_FFF5);
    issue_access(OP_TICK, 2'd0, '0);
    issue_access(OP_READ, 2'd0, '0);
    issue_access(OP_STOP, 2'd0, 32'hF);
    issue_access(OP_TICK, 2'd0, VISIBLE_RESET);

    // Dropping from a large divider to a small one often leaves the phase
    // above the new divider.
    run_phase(32'd1, 0, 0, 300, 1'b0);
    run_phase(32'd2, 84, 0, 200, 1'b0);
    run_phase(32'd60, 0, 84, 200, 1'b0);
    run_phase(32'd2, 15, 15, 250, 1'b0);
    run_phase(32'd3, 0, 84, 250, 1'b0);
    run_phase('0, 0, 0, 150, 1'b0);
    run_phase(32'd1, 15, 15, 250, 1'b1);
    run_phase(VISIBLE_RESET, 0, 84, 100, 1'b0);
    run_phase(32'd5, 84, 0, 250, 1'b0);

    in_if.valid    <= 1'b0;
    recv_stall_pct = 0;
    drain_cycles   = 0;
    @(posedge clk_i);
    while (outstanding != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
